/* src/emv_pkg.sv */
`timescale 1ns / 1ps

package emv_pkg;

   localparam int SAMPLE_BITS_DEFAULT   = 24;
   localparam int FRACTION_BITS_DEFAULT = 16;

   localparam int ALPHA_FRAC_BITS = 16;
   localparam int ALPHA_BITS      = ALPHA_FRAC_BITS + 1;
   localparam logic [ALPHA_BITS-1:0] ALPHA_ONE   = ALPHA_BITS'(1) << ALPHA_FRAC_BITS;
   localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = ALPHA_BITS'(6554);

   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   localparam int DIGIT_BITS = 32;
   localparam int OP_BITS    = 2 * DIGIT_BITS;
   localparam int ACC_BITS   = 2 * OP_BITS;
   localparam int VAR_BITS   = 64;
   localparam int VAR_OUT_BITS = 48;

   localparam logic [1:0] PHASE_SCALE    = 2'd0;
   localparam logic [1:0] PHASE_SQUARE   = 2'd1;
   localparam logic [1:0] PHASE_VARIANCE = 2'd2;

endpackage

/* src/exp_moving_variance.sv */
`timescale 1ns / 1ps

// a seeding item goes from ST_DIFF straight to ST_DONE; any later item passes through
// ST_DIFF, then ST_MUL and ST_POST once per product, then ST_DONE; the three 64x64
// products run as 4 partial products each through one shared 32x32 multiplier; one item
// is taken at a time. the result register frees the input as soon as the result is loaded.
// reset (synchronous, active high) clears mean, variance and seeding, alpha to 6554.
module exp_moving_variance #(
   parameter int SAMPLE_BITS   = emv_pkg::SAMPLE_BITS_DEFAULT,
   parameter int FRACTION_BITS = emv_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [emv_pkg::VAR_OUT_BITS-1:0]    rsp_variance_value,
   output logic signed [SAMPLE_BITS-1:0]       rsp_mean_value,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [emv_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [emv_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [emv_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);

   localparam int MEAN_BITS = SAMPLE_BITS + FRACTION_BITS;
   localparam int DIFF_BITS = MEAN_BITS + 1;
   localparam int OPB = emv_pkg::OP_BITS;
   localparam int ACB = emv_pkg::ACC_BITS;
   localparam int DGB = emv_pkg::DIGIT_BITS;
   localparam int VB  = emv_pkg::VAR_BITS;
   localparam int AB  = emv_pkg::ALPHA_BITS;
   localparam int AFB = emv_pkg::ALPHA_FRAC_BITS;
   localparam int VOB = emv_pkg::VAR_OUT_BITS;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIFF = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_POST = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   localparam logic [2:0] MUL_STEPS = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic [1:0]                   phase_ff, phase_in;
   logic [2:0]                   cnt_ff, cnt_in;
   logic                         seeded_ff, seeded_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic signed [MEAN_BITS-1:0]  mean_ff, mean_in;
   logic [VB-1:0]                var_ff, var_in;
   logic                         neg_ff, neg_in;
   logic [OPB-1:0]               mag_ff, mag_in;
   logic [OPB-1:0]               op_a_ff, op_a_in;
   logic [OPB-1:0]               op_b_ff, op_b_in;
   logic [OPB-1:0]               prod_ff, prod_in;
   logic [1:0]                   shift_ff, shift_in;
   logic [ACB-1:0]               acc_ff, acc_in;
   logic [AB-1:0]                alpha_ff, alpha_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [VOB-1:0]               rsp_var_ff, rsp_var_in;
   logic signed [SAMPLE_BITS-1:0] rsp_mean_ff, rsp_mean_in;

   logic                         csr_write;
   logic [AB-1:0]                alpha_eff;
   logic [AB-1:0]                alpha_comp;
   logic signed [MEAN_BITS-1:0]  sample_scaled;
   logic signed [DIFF_BITS-1:0]  diff;
   logic [DIFF_BITS-1:0]         diff_mag;
   logic [DGB-1:0]               dig_a, dig_b;
   logic [ACB-1:0]               prod_shifted;
   logic [OPB-1:0]               acc_alpha_shr;
   logic [OPB-1:0]               term;
   logic [VB:0]                  sum_wide;
   logic [VB-1:0]                sum_sat;
   logic signed [DIFF_BITS-1:0]  mean_wide;
   logic [VB-1:0]                var_shr;
   logic                         out_free;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];
   assign csr_prdata = csr_paddr[2] ? '0 : emv_pkg::CSR_DATA_BITS'(alpha_ff);

   assign alpha_eff  = alpha_ff[AB-1] ? emv_pkg::ALPHA_ONE : alpha_ff;
   assign alpha_comp = emv_pkg::ALPHA_ONE - alpha_eff;

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_variance_value = rsp_var_ff;
   assign rsp_mean_value     = rsp_mean_ff;
   assign out_free           = !rsp_valid_ff || !rsp_stall;

   assign sample_scaled = {sample_ff, {FRACTION_BITS{1'b0}}};
   assign diff     = DIFF_BITS'(sample_scaled) - DIFF_BITS'(mean_ff);
   assign diff_mag = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);

   // partial product digit select
   assign dig_a = cnt_ff[0] ? op_a_ff[OPB-1:DGB] : op_a_ff[DGB-1:0];
   assign dig_b = cnt_ff[1] ? op_b_ff[OPB-1:DGB] : op_b_ff[DGB-1:0];

   always_comb begin
      case (shift_ff)
         2'd0:    prod_shifted = {{OPB{1'b0}}, prod_ff};
         2'd1:    prod_shifted = {{DGB{1'b0}}, prod_ff, {DGB{1'b0}}};
         default: prod_shifted = {prod_ff, {OPB{1'b0}}};
      endcase
   end

   assign acc_alpha_shr = acc_ff[AFB +: OPB];
   assign term = (acc_ff[ACB-1:OPB+FRACTION_BITS] != '0) ? '1 : acc_ff[FRACTION_BITS +: OPB];
   assign sum_wide  = {1'b0, var_ff} + {1'b0, term};
   assign sum_sat   = sum_wide[VB] ? '1 : sum_wide[VB-1:0];
   assign mean_wide = neg_ff ? DIFF_BITS'(mean_ff) - $signed(acc_alpha_shr[DIFF_BITS-1:0])
                             : DIFF_BITS'(mean_ff) + $signed(acc_alpha_shr[DIFF_BITS-1:0]);
   assign var_shr   = var_ff >> FRACTION_BITS;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      seeded_in    = seeded_ff;
      sample_in    = sample_ff;
      mean_in      = mean_ff;
      var_in       = var_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      op_a_in      = op_a_ff;
      op_b_in      = op_b_ff;
      prod_in      = prod_ff;
      shift_in     = shift_ff;
      acc_in       = acc_ff;
      alpha_in     = csr_write ? csr_pwdata[AB-1:0] : alpha_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_var_in   = rsp_var_ff;
      rsp_mean_in  = rsp_mean_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_sample;
               state_in  = ST_DIFF;
            end
         end
         ST_DIFF: begin
            if (!seeded_ff) begin
               mean_in   = sample_scaled;
               var_in    = '0;
               seeded_in = 1'b1;
               state_in  = ST_DONE;
            end else begin
               neg_in   = diff[DIFF_BITS-1];
               mag_in   = OPB'(diff_mag);
               op_a_in  = OPB'(diff_mag);
               op_b_in  = OPB'(alpha_eff);
               phase_in = emv_pkg::PHASE_SCALE;
               cnt_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (cnt_ff != MUL_STEPS) begin
               prod_in  = OPB'(dig_a) * OPB'(dig_b);
               shift_in = 2'(cnt_ff[0]) + 2'(cnt_ff[1]);
            end
            if (cnt_ff == '0) begin
               acc_in = '0;
            end else begin
               acc_in = acc_ff + prod_shifted;
            end
            if (cnt_ff == MUL_STEPS) begin
               state_in = ST_POST;
            end
            cnt_in = cnt_ff + 3'd1;
         end
         ST_POST: begin
            cnt_in   = '0;
            state_in = ST_MUL;
            unique case (phase_ff)
               emv_pkg::PHASE_SCALE: begin
                  mean_in  = mean_wide[MEAN_BITS-1:0];
                  op_a_in  = acc_alpha_shr;
                  op_b_in  = mag_ff;
                  phase_in = emv_pkg::PHASE_SQUARE;
               end
               emv_pkg::PHASE_SQUARE: begin
                  op_a_in  = sum_sat;
                  op_b_in  = OPB'(alpha_comp);
                  phase_in = emv_pkg::PHASE_VARIANCE;
               end
               default: begin
                  var_in   = acc_alpha_shr;
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_var_in   = (var_shr[VB-1:VOB] != '0) ? '1 : var_shr[VOB-1:0];
               rsp_mean_in  = SAMPLE_BITS'(mean_ff >>> FRACTION_BITS);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= emv_pkg::PHASE_SCALE;
         cnt_ff       <= '0;
         seeded_ff    <= 1'b0;
         mean_ff      <= '0;
         var_ff       <= '0;
         alpha_ff     <= emv_pkg::ALPHA_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         seeded_ff    <= seeded_in;
         mean_ff      <= mean_in;
         var_ff       <= var_in;
         alpha_ff     <= alpha_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      op_a_ff     <= op_a_in;
      op_b_ff     <= op_b_in;
      prod_ff     <= prod_in;
      shift_ff    <= shift_in;
      acc_ff      <= acc_in;
      rsp_var_ff  <= rsp_var_in;
      rsp_mean_ff <= rsp_mean_in;
   end

endmodule

/* test/exp_moving_variance_test.sv */
`timescale 1ns / 1ps

module exp_moving_variance_test;

   localparam int SAMPLE_W = emv_pkg::SAMPLE_BITS_DEFAULT;
   localparam int VAR_W    = emv_pkg::VAR_OUT_BITS;
   localparam int IDLE_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 25;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 195;
   localparam logic [emv_pkg::CSR_ADDR_BITS-1:0] ALPHA_ADDR = 3'd0;
   localparam logic [emv_pkg::CSR_ADDR_BITS-1:0] STRAY_ADDR = 3'd4;
   localparam int unsigned ALPHA_PLAN [8] = '{0, 65536, 131071, 1, 65535, 6554, 32768,
                                              49152};

   typedef struct packed {
      logic [VAR_W-1:0]           variance;
      logic signed [SAMPLE_W-1:0] mean;
   } stats_type;

   typedef struct packed {
      bit        pinned;
      stats_type stats;
   } item_note_type;

   typedef enum logic [1:0] {ROW_SAMPLE, ROW_ALPHA, ROW_STRAY_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      logic [31:0]      value;
      bit               pinned;
      logic [VAR_W-1:0] variance;
      logic [31:0]      mean;
   } row_type;

   localparam int ROWS = 29;
   localparam row_type SCRIPT [ROWS] = '{
      '{ROW_SAMPLE, 32'sd8388607, 1'b1, 48'd0, 32'sd8388607},
      '{ROW_SAMPLE, -32'sd8388608, 1'b0, 48'd0, 32'sd0},
      '{ROW_SAMPLE, 32'sd0, 1'b0, 48'd0, 32'sd0},
      '{ROW_ALPHA, 32'd65536, 1'b0, 48'd0, 32'sd0},
      '{ROW_SAMPLE, -32'sd8388608, 1'b1, 48'd0, -32'sd8388608},
      '{ROW_SAMPLE, 32'sd8388607, 1'b1, 48'd0, 32'sd8388607},
      '{ROW_ALPHA, 32'd0, 1'b0, 48'd0, 32'sd0},
      '{ROW_SAMPLE, 32'sd12345, 1'b1, 48'd0, 32'sd8388607},
      '{ROW_SAMPLE, -32'sd8388608, 1'b1, 48'd0, 32'sd8388607},
      '{ROW_ALPHA, 32'd131071, 1'b0, 48'd0, 32'sd0},
      '{ROW_SAMPLE, -32'sd8388608, 1'b1, 48'd0, -32'sd8388608},
      '{ROW_ALPHA, 32'hFFFE0001, 1'b0, 48'd0, 32'sd0},
      '{ROW_SAMPLE, 32'sd8388607, 1'b0, 48'd0, 32'sd0},
      '{ROW_SAMPLE, -32'sd1, 1'b0, 48'd0, 32'sd0},
      '{ROW_ALPHA, 32'd32768, 1'b0, 48'd0, 32'sd0},
      '{ROW_SAMPLE, 32'sd8388607, 1'b0, 48'd0, 32'sd0},
      '{ROW_SAMPLE, -32'sd8388608, 1'b0, 48'd0, 32'sd0},
      '{ROW_SAMPLE, 32'sd8388607, 1'b0, 48'd0, 32'sd0},
      '{ROW_STRAY_WRITE, 32'd0, 1'b0, 48'd0, 32'sd0},
      '{ROW_SAMPLE, -32'sd8388608, 1'b0, 48'd0, 32'sd0},
      '{ROW_SAMPLE, -32'sd1, 1'b0, 48'd0, 32'sd0},
      '{ROW_ALPHA, 32'd65535, 1'b0, 48'd0, 32'sd0},
      '{ROW_SAMPLE, 32'sd8388607, 1'b0, 48'd0, 32'sd0},
      '{ROW_SAMPLE, -32'sd8388608, 1'b0, 48'd0, 32'sd0},
      '{ROW_SAMPLE, 32'sd8388607, 1'b0, 48'd0, 32'sd0},
      '{ROW_SAMPLE, -32'sd8388608, 1'b0, 48'd0, 32'sd0},
      '{ROW_ALPHA, 32'd6554, 1'b0, 48'd0, 32'sd0},
      '{ROW_SAMPLE, 32'sd1, 1'b0, 48'd0, 32'sd0},
      '{ROW_SAMPLE, -32'sd2, 1'b0, 48'd0, 32'sd0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [VAR_W-1:0] rsp_variance_value;
   logic signed [SAMPLE_W-1:0] rsp_mean_value;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [emv_pkg::CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [emv_pkg::CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [emv_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   exp_moving_variance dut (.*);

   always #10 clock = ~clock;

   // running state of the block as predicted
   logic [emv_pkg::ALPHA_BITS-1:0] alpha_reg = emv_pkg::ALPHA_RESET;
   longint mean_acc = 0;
   bit [63:0] var_acc = '0;
   bit seeded = 1'b0;

   stats_type expected_stats_q[$];
   item_note_type pinned_q[$];
   bit quiet = 1'b0;
   int mismatches = 0;
   int samples_sent = 0;
   int results_checked = 0;
   int settings_used = 0;
   int idle_cycles = 0;

   function automatic bit [63:0] scaled_product(input bit [63:0] x, input bit [63:0] y,
                                                input int sh);
      bit [127:0] p;
      p = {64'd0, x} * {64'd0, y};
      p = p >> sh;
      if (p[127:64] != 0) return '1;
      return p[63:0];
   endfunction

   function automatic stats_type advance_stats(input logic signed [SAMPLE_W-1:0] x);
      longint xs;
      longint d;
      bit neg;
      bit [63:0] a, mag, scaled, t, s;
      stats_type r;
      xs = longint'(x) * (longint'(1) << emv_pkg::FRACTION_BITS_DEFAULT);
      a = (alpha_reg > emv_pkg::ALPHA_ONE) ? 64'(emv_pkg::ALPHA_ONE) : 64'(alpha_reg);
      if (!seeded) begin
         mean_acc = xs;
         var_acc = '0;
         seeded = 1'b1;
      end else begin
         d = xs - mean_acc;
         neg = d < 0;
         mag = neg ? 64'(-d) : 64'(d);
         scaled = scaled_product(mag, a, emv_pkg::ALPHA_FRAC_BITS);
         mean_acc = neg ? mean_acc - longint'(scaled) : mean_acc + longint'(scaled);
         t = scaled_product(scaled, mag, emv_pkg::FRACTION_BITS_DEFAULT);
         s = var_acc + t;
         if (s < t) s = '1;
         var_acc = scaled_product(s, 64'(emv_pkg::ALPHA_ONE) - a, emv_pkg::ALPHA_FRAC_BITS);
      end
      r.variance = var_acc[63:emv_pkg::FRACTION_BITS_DEFAULT];
      r.mean = SAMPLE_W'(mean_acc >>> emv_pkg::FRACTION_BITS_DEFAULT);
      return r;
   endfunction

   always @(posedge clock) begin
      item_note_type note;
      stats_type want;
      if (req_valid && !req_stall) begin
         note = pinned_q.pop_front();
         want = advance_stats(req_sample);
         expected_stats_q.push_back(note.pinned ? note.stats : want);
      end
      if (rsp_valid && !rsp_stall) begin
         if (expected_stats_q.size() == 0) begin
            $error("result with no item waiting: variance %0d mean %0d",
                   rsp_variance_value, rsp_mean_value);
            mismatches++;
         end else begin
            want = expected_stats_q.pop_front();
            results_checked++;
            if (rsp_variance_value !== want.variance) begin
               $error("variance_value: expected %0d, got %0d", want.variance,
                      rsp_variance_value);
               mismatches++;
            end
            if (rsp_mean_value !== want.mean) begin
               $error("mean_value: expected %0d, got %0d", want.mean, rsp_mean_value);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout with %0d results outstanding", expected_stats_q.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result side back-pressure
   initial begin
      int n;
      forever begin
         n = quiet ? 0 : $urandom_range(0, 9);
         if (n != 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] x, input bit pinned,
                              input stats_type pin);
      int gap;
      item_note_type note;
      gap = quiet ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      note.pinned = pinned;
      note.stats = pin;
      pinned_q.push_back(note);
      req_valid <= 1'b1;
      req_sample <= x;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      samples_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_stats_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input logic [emv_pkg::CSR_ADDR_BITS-1:0] addr,
                             input logic [emv_pkg::CSR_DATA_BITS-1:0] data,
                             output logic [emv_pkg::CSR_DATA_BITS-1:0] rd);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rd = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_alpha(input logic [emv_pkg::CSR_ADDR_BITS-1:0] addr,
                            input logic [emv_pkg::CSR_DATA_BITS-1:0] value);
      logic [emv_pkg::CSR_DATA_BITS-1:0] rd;
      settle();
      csr_access(1'b1, addr, value, rd);
      if (addr == ALPHA_ADDR) begin
         alpha_reg = value[emv_pkg::ALPHA_BITS-1:0];
         settings_used++;
      end
      csr_access(1'b0, ALPHA_ADDR, '0, rd);
      if (rd !== emv_pkg::CSR_DATA_BITS'(alpha_reg)) begin
         $error("smoothing_factor: expected %0d, got %0d", alpha_reg, rd);
         mismatches++;
      end
   endtask

   initial begin
      logic signed [SAMPLE_W-1:0] x;
      logic signed [SAMPLE_W-1:0] prev;
      logic [emv_pkg::CSR_DATA_BITS-1:0] alpha;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < ROWS; i++) begin
         case (SCRIPT[i].kind)
            ROW_SAMPLE: begin
               send_sample(SCRIPT[i].value[SAMPLE_W-1:0], SCRIPT[i].pinned,
                           stats_type'{SCRIPT[i].variance, SCRIPT[i].mean[SAMPLE_W-1:0]});
            end
            ROW_ALPHA: begin
               set_alpha(ALPHA_ADDR, SCRIPT[i].value);
            end
            default: begin
               set_alpha(STRAY_ADDR, SCRIPT[i].value);
            end
         endcase
      end

      prev = '0;
      for (int p = 0; p < PHASES; p++) begin
         alpha = (p < 8) ? ALPHA_PLAN[p] : $urandom_range(0, 131071);
         set_alpha(ALPHA_ADDR, alpha);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
               0, 1, 2, 3: x = SAMPLE_W'($urandom);
               4, 5, 6: x = prev + SAMPLE_W'($urandom_range(0, 511)) - SAMPLE_W'(256);
               7: x = {1'b0, {(SAMPLE_W-1){1'b1}}};
               8: x = {1'b1, {(SAMPLE_W-1){1'b0}}};
               default: x = $urandom_range(0, 1) ? '0 : '1;
            endcase
            send_sample(x, 1'b0, '0);
            prev = x;
         end
         quiet = 1'b0;
      end

      settle();
      $display("%0d samples sent, %0d results checked across %0d smoothing settings",
               samples_sent, results_checked, settings_used);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
